/* rtl/core/csd_pkg.sv */
// ----------------------------------------------------------------------------
// csd_pkg
// shared types and constants of the camera record stream deframer
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam logic [31:0] MAGIC_WORD   = 32'h5348_464C;
  localparam logic [7:0]  EXT_FLAG_VAL = 8'h01;
  localparam logic [31:0] BASE_SUB     = 32'd24;
  localparam logic [31:0] EXT_EXTRA    = 32'd12;
  localparam logic [6:0]  BASE_HDR     = 7'd68;
  localparam logic [6:0]  EXT_HDR      = 7'd80;
  localparam logic [23:0] SKIP_RESET   = 24'd1048576;
  localparam logic [23:0] SKIP_MAX     = 24'hFF_FFFF;

  localparam logic [6:0] IDX_START  = 7'd4;
  localparam logic [6:0] IDX_EXT    = 7'd7;
  localparam logic [6:0] IDX_TOTAL  = 7'd24;
  localparam logic [6:0] IDX_PACKET = 7'd48;
  localparam logic [6:0] IDX_TIME   = 7'd60;
  localparam logic [6:0] IDX_TIME_L = 7'd67;
  localparam logic [6:0] IDX_CODEC  = 7'd72;
  localparam logic [6:0] IDX_DIMS   = 7'd76;

  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] ADDR_MAX_SKIP = 2'd0;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_HEADER    = 2'd1,
    KIND_SYNC_LOST = 2'd2,
    KIND_HDR_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'b001,
    ST_HEADER  = 3'b010,
    ST_PAYLOAD = 3'b100
  } state_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   out_byte;
    logic         last;
    logic [63:0]  timestamp;
    logic [31:0]  payload_len;
    logic         codec_present;
    logic [31:0]  fourcc;
    logic [15:0]  width;
    logic [15:0]  height;
  } result_t;

endpackage

/* rtl/core/csd_raw_if.sv */
// ----------------------------------------------------------------------------
// csd_raw_if
// byte stream channel into the deframer
// ----------------------------------------------------------------------------
interface csd_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

/* rtl/core/csd_res_if.sv */
// ----------------------------------------------------------------------------
// csd_res_if
// result channel out of the deframer
// ----------------------------------------------------------------------------
interface csd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        last;
  logic [63:0] timestamp;
  logic [31:0] payload_len;
  logic        codec_present;
  logic [31:0] fourcc;
  logic [15:0] width;
  logic [15:0] height;

  modport source (
    output valid, output kind, output out_byte, output last, output timestamp,
    output payload_len, output codec_present, output fourcc, output width,
    output height, input ready
  );
  modport sink (
    input valid, input kind, input out_byte, input last, input timestamp,
    input payload_len, input codec_present, input fourcc, input width,
    input height, output ready
  );
endinterface

/* rtl/core/csd_parser.sv */
// ----------------------------------------------------------------------------
// csd_parser
// magic hunt, header capture and payload count, one byte per step
// ----------------------------------------------------------------------------
module csd_parser import csd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic [23:0] max_skip,
  output logic        res_valid,
  output result_t     res
);

  state_t      state, state_next;
  logic [23:0] recent, recent_next;
  logic [6:0]  hdr_idx, hdr_idx_next;
  logic        ext_flag, ext_flag_next;
  logic [23:0] skip_count, skip_count_next;
  logic        loss_reported, loss_reported_next;
  logic [31:0] total_len, total_len_next;
  logic [31:0] packet_len, packet_len_next;
  logic [63:0] time_reg, time_reg_next;
  logic [31:0] codec_reg, codec_reg_next;
  logic [31:0] dims_reg, dims_reg_next;
  logic [31:0] remaining, remaining_next;

  logic [31:0] window;
  logic [23:0] skip_inc;
  logic [6:0]  time_off;
  logic [4:0]  lane_sh;
  logic [5:0]  time_sh;
  logic [6:0]  hdr_len;
  logic [31:0] sub;
  logic [31:0] rem;
  logic [31:0] rem_dec;

  assign window   = {recent, data_byte};
  assign skip_inc = (skip_count < SKIP_MAX) ? skip_count + 24'd1 : skip_count;
  assign time_off = hdr_idx - IDX_TIME;
  assign lane_sh  = {hdr_idx[1:0], 3'b000};
  assign time_sh  = {time_off[2:0], 3'b000};
  assign hdr_len  = ext_flag_next ? EXT_HDR : BASE_HDR;
  assign sub      = ext_flag_next ? BASE_SUB + EXT_EXTRA : BASE_SUB;
  assign rem      = total_len_next - sub;
  assign rem_dec  = (remaining != 32'd0) ? remaining - 32'd1 : 32'd0;

  always_comb begin
    state_next         = state;
    recent_next        = recent;
    hdr_idx_next       = hdr_idx;
    ext_flag_next      = ext_flag;
    skip_count_next    = skip_count;
    loss_reported_next = loss_reported;
    total_len_next     = total_len;
    packet_len_next    = packet_len;
    time_reg_next      = time_reg;
    codec_reg_next     = codec_reg;
    dims_reg_next      = dims_reg;
    remaining_next     = remaining;
    res_valid          = 1'b0;
    res                = '0;

    unique case (state)
      ST_HUNT: begin
        recent_next = window[23:0];
        if (window == MAGIC_WORD) begin
          state_next         = ST_HEADER;
          hdr_idx_next       = IDX_START;
          ext_flag_next      = 1'b0;
          total_len_next     = '0;
          packet_len_next    = '0;
          time_reg_next      = '0;
          codec_reg_next     = '0;
          dims_reg_next      = '0;
          skip_count_next    = '0;
          loss_reported_next = 1'b0;
        end else if (skip_inc > max_skip && !loss_reported) begin
          loss_reported_next = 1'b1;
          skip_count_next    = '0;
          res_valid          = 1'b1;
          res.kind           = KIND_SYNC_LOST;
        end else begin
          skip_count_next = skip_inc;
        end
      end
      ST_HEADER: begin
        if (hdr_idx == IDX_EXT) begin
          ext_flag_next = (data_byte == EXT_FLAG_VAL);
        end else if (hdr_idx[6:2] == IDX_TOTAL[6:2]) begin
          total_len_next = total_len | ({24'b0, data_byte} << lane_sh);
        end else if (hdr_idx[6:2] == IDX_PACKET[6:2]) begin
          packet_len_next = packet_len | ({24'b0, data_byte} << lane_sh);
        end else if (hdr_idx >= IDX_TIME && hdr_idx <= IDX_TIME_L) begin
          time_reg_next = time_reg | ({56'b0, data_byte} << time_sh);
        end else if (hdr_idx[6:2] == IDX_CODEC[6:2]) begin
          codec_reg_next = codec_reg | ({24'b0, data_byte} << lane_sh);
        end else if (hdr_idx[6:2] == IDX_DIMS[6:2]) begin
          dims_reg_next = dims_reg | ({24'b0, data_byte} << lane_sh);
        end

        if (hdr_idx + 7'd1 < hdr_len) begin
          hdr_idx_next = hdr_idx + 7'd1;
        end else begin
          res_valid = 1'b1;
          if (packet_len_next > total_len_next || total_len_next < sub) begin
            res.kind     = KIND_HDR_ERROR;
            state_next   = ST_HUNT;
            recent_next  = '0;
            hdr_idx_next = '0;
          end else begin
            remaining_next    = rem;
            res.kind          = KIND_HEADER;
            res.last          = (rem == 32'd0);
            res.timestamp     = time_reg_next;
            res.payload_len   = rem;
            res.codec_present = ext_flag_next;
            if (ext_flag_next) begin
              res.fourcc = codec_reg_next;
              res.width  = dims_reg_next[15:0];
              res.height = dims_reg_next[31:16];
            end
            if (rem == 32'd0) begin
              state_next   = ST_HUNT;
              recent_next  = '0;
              hdr_idx_next = '0;
            end else begin
              state_next = ST_PAYLOAD;
            end
          end
        end
      end
      ST_PAYLOAD: begin
        res_valid      = 1'b1;
        res.kind       = KIND_PAYLOAD;
        res.out_byte   = data_byte;
        remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          res.last     = 1'b1;
          state_next   = ST_HUNT;
          recent_next  = '0;
          hdr_idx_next = '0;
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_HUNT;
      recent        <= '0;
      hdr_idx       <= '0;
      ext_flag      <= 1'b0;
      skip_count    <= '0;
      loss_reported <= 1'b0;
    end else if (step) begin
      state         <= state_next;
      recent        <= recent_next;
      hdr_idx       <= hdr_idx_next;
      ext_flag      <= ext_flag_next;
      skip_count    <= skip_count_next;
      loss_reported <= loss_reported_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      total_len  <= total_len_next;
      packet_len <= packet_len_next;
      time_reg   <= time_reg_next;
      codec_reg  <= codec_reg_next;
      dims_reg   <= dims_reg_next;
      remaining  <= remaining_next;
    end
  end

endmodule

/* rtl/core/camera_record_stream_deframer.sv */
// ----------------------------------------------------------------------------
// camera_record_stream_deframer
// one byte in per cycle unless stalled; header, payload, sync-loss, error out
// a result is registered, valid in the cycle after the byte that causes it
// throughput: one byte per cycle unless stalled by the single result register
// a byte is taken while a result waits as long as that result is taken too
// reset: hunting for magic, window and counters cleared, max_skip 1048576
// ----------------------------------------------------------------------------
module camera_record_stream_deframer import csd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  csd_raw_if.sink           raw,
  csd_res_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [23:0] max_skip;
  logic        step;
  logic        res_valid;
  result_t     res;
  logic        out_valid;
  result_t     out_q;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_SKIP) ? {8'b0, max_skip} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_skip <= SKIP_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_MAX_SKIP) begin
      max_skip <= pwdata[23:0];
    end
  end

  assign raw.ready = !out_valid || result.ready;
  assign step      = raw.valid && raw.ready;

  csd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (raw.data_byte),
    .max_skip  (max_skip),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_q.kind;
  assign result.out_byte      = out_q.out_byte;
  assign result.last          = out_q.last;
  assign result.timestamp     = out_q.timestamp;
  assign result.payload_len   = out_q.payload_len;
  assign result.codec_present = out_q.codec_present;
  assign result.fourcc        = out_q.fourcc;
  assign result.width         = out_q.width;
  assign result.height        = out_q.height;

  a_new_result_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(raw.valid && raw.ready))
    else $error("result appeared without an accepted byte");

  a_header_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_HEADER)
      |-> (result.last == (result.payload_len == 32'd0)))
    else $error("header last flag disagrees with payload length");

  a_no_codec_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_HEADER && !result.codec_present)
      |-> (result.fourcc == 32'd0 && result.width == 16'd0 && result.height == 16'd0))
    else $error("codec fields set without extension");

endmodule
